/* design/arsd_pkg.sv */
// Shared constants, types and codes for the address region split decoder.
// Depends on nothing; every other file of the block imports it.
package arsd_pkg;

	// Build-time sizing of the decoder.
	localparam int NUM_REGIONS = 4;
	localparam int ADDR_WIDTH = 32;

	// Register file layout: four region slots, then the two enable registers.
	localparam int REG_SLOTS = 4;
	localparam int NUM_SEARCHED = (NUM_REGIONS < REG_SLOTS) ? NUM_REGIONS : REG_SLOTS;
	localparam int SLOT_W = $clog2(REG_SLOTS);
	localparam int REG_IDX_W = 3;
	localparam int CFG_AW = REG_IDX_W + 3;
	localparam int CFG_DW = 64;

	// Field widths of the item channels.
	localparam int FIELD_W = 32;
	localparam int IDX_W = 3;
	// Region end (base + size) never wraps, so it needs one extra bit.
	localparam int END_W = FIELD_W + 1;
	localparam int DIFF_W = END_W + 1;

	// Size of the address space, one past the highest address.
	localparam logic [END_W-1:0] SPACE = END_W'(1) << ADDR_WIDTH;

	// Register indexes beyond the region slots.
	localparam logic [REG_IDX_W-1:0] REG_HANDLER = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT = 3'd5;

	// Region index reported for the default handler.
	localparam logic [IDX_W-1:0] DEFAULT_IDX = 3'd4;

	// Completion codes of a segment.
	typedef enum logic [1:0] {
		ST_SERVED = 2'd0,
		ST_ABSENT = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} sts_t;

endpackage

/* design/arsd_req_if.sv */
// Request channel: one access item with direction, start address and byte count.
// Depends on arsd_pkg for the field widths.
interface arsd_req_if
	import arsd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               action;
	logic [FIELD_W-1:0] start_address;
	logic [FIELD_W-1:0] byte_count;

	modport source (output valid, action, start_address, byte_count, input ready);
	modport sink (input valid, action, start_address, byte_count, output ready);
endinterface

/* design/arsd_seg_if.sv */
// Segment channel: one routed piece of an access per item.
// Depends on arsd_pkg for the field widths and the status type.
interface arsd_seg_if
	import arsd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   region_index;
	logic [FIELD_W-1:0] segment_address;
	logic [FIELD_W-1:0] segment_length;
	status_t            status;
	logic               last;

	modport source (output valid, region_index, segment_address, segment_length, status, last,
		input ready);
	modport sink (input valid, region_index, segment_address, segment_length, status, last,
		output ready);
endinterface

/* design/address_region_split_decoder_core.sv */
// The first segment of an access is decoded from the state loaded at item acceptance and enters the output
// register when it has room. Throughput: an access splits into k segments (1 to 5), one decode cycle per
// segment through the parallel region comparators while the segment sink does not stall.
// Reset: asynchronous; regions clear to zero, handler enables to 0, default enables to 3.
// No memory clearing pass; the block is ready for items as soon as reset is released.
// Depends on arsd_pkg, arsd_req_if, arsd_seg_if, arsd_datapath and arsd_ctrl.
module address_region_split_decoder_core
	import arsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	arsd_req_if.sink          req,
	arsd_seg_if.source        seg,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cmd_t cmd;
	sts_t sts;

	// Register accesses complete without wait states.
	assign pready = 1'b1;

	arsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (seg.valid),
		.out_ready (seg.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	arsd_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.in_action           (req.action),
		.in_start_address    (req.start_address),
		.in_byte_count       (req.byte_count),
		.out_region_index    (seg.region_index),
		.out_segment_address (seg.segment_address),
		.out_segment_length  (seg.segment_length),
		.out_status          (seg.status),
		.out_last            (seg.last),
		.cmd                 (cmd),
		.sts                 (sts)
	);

endmodule

/* design/arsd_datapath.sv */
// Datapath of the region decoder: register file, access state, region
// comparators and the output register. Depends on arsd_pkg.
module arsd_datapath
	import arsd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write and read.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [CFG_DW-1:0]   pwdata,
	output logic [CFG_DW-1:0]   prdata,
	// Incoming access.
	input  logic                in_action,
	input  logic [FIELD_W-1:0]  in_start_address,
	input  logic [FIELD_W-1:0]  in_byte_count,
	// Outgoing segment payload.
	output logic [IDX_W-1:0]    out_region_index,
	output logic [FIELD_W-1:0]  out_segment_address,
	output logic [FIELD_W-1:0]  out_segment_length,
	output status_t             out_status,
	output logic                out_last,
	// Controller link.
	input  cmd_t                cmd,
	output sts_t                sts
);

	// Register file.
	logic [CFG_DW-1:0]     region_q [REG_SLOTS];
	logic [END_W-1:0]      end_q [REG_SLOTS];
	logic                  term_q [REG_SLOTS];
	logic [2*REG_SLOTS-1:0] handler_q;
	logic [1:0]            default_q;

	// Access in progress.
	logic [ADDR_WIDTH-1:0] cur_q;
	logic [FIELD_W-1:0]    rem_q;
	logic                  dir_q;
	logic                  empty_q;

	// Output register.
	logic [IDX_W-1:0]      idx_q;
	logic [FIELD_W-1:0]    addr_q;
	logic [FIELD_W-1:0]    len_q;
	status_t               status_q;
	logic                  last_q;

	logic                  cfg_wr;
	logic [REG_IDX_W-1:0]  cfg_idx;

	logic [END_W-1:0]      space_left;
	logic [FIELD_W-1:0]    clip_count;

	logic [DIFF_W-1:0]     lane_d [NUM_SEARCHED];
	logic                  lane_in [NUM_SEARCHED];
	logic                  hit;
	logic                  stop;
	logic [SLOT_W-1:0]     hidx;
	logic [END_W-1:0]      dsel;
	logic [ADDR_WIDTH-1:0] esel;
	logic [DIFF_W-1:0]     diff;
	logic                  fits_all;
	logic                  enabled;

	logic [IDX_W-1:0]      res_idx;
	logic [FIELD_W-1:0]    res_len;
	status_t               res_status;
	logic                  res_last;

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[CFG_AW-1:3];

	// Register file writes; the region end is worked out once at write time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_SLOTS; i++) begin
				region_q[i] <= '0;
				end_q[i]    <= '0;
				term_q[i]   <= 1'b1;
			end
			handler_q <= '0;
			default_q <= 2'b11;
		end else if (cfg_wr) begin
			for (int i = 0; i < REG_SLOTS; i++) begin
				if (cfg_idx == REG_IDX_W'(i)) begin
					region_q[i] <= pwdata;
					end_q[i]    <= END_W'(pwdata[ADDR_WIDTH-1:0]) + END_W'(pwdata[63:32]);
					term_q[i]   <= (pwdata == '0);
				end
			end
			if (cfg_idx == REG_HANDLER) begin
				handler_q <= pwdata[2*REG_SLOTS-1:0];
			end
			if (cfg_idx == REG_DEFAULT) begin
				default_q <= pwdata[1:0];
			end
		end
	end

	// Register read-back.
	always_comb begin
		if (cfg_idx < REG_IDX_W'(REG_SLOTS)) begin
			prdata = region_q[cfg_idx[SLOT_W-1:0]];
		end else if (cfg_idx == REG_HANDLER) begin
			prdata = CFG_DW'(handler_q);
		end else if (cfg_idx == REG_DEFAULT) begin
			prdata = CFG_DW'(default_q);
		end else begin
			prdata = '0;
		end
	end

	// A byte count that runs past the top of the address space is cut so that the access ends there.
	always_comb begin
		space_left = SPACE - END_W'(in_start_address[ADDR_WIDTH-1:0]);
		if (END_W'(in_byte_count) > space_left) begin
			clip_count = space_left[FIELD_W-1:0];
		end else begin
			clip_count = in_byte_count;
		end
	end

	// One comparator lane per searched region: distance from the address to the region end.
	always_comb begin
		for (int i = 0; i < NUM_SEARCHED; i++) begin
			lane_d[i]  = DIFF_W'(end_q[i]) - DIFF_W'(cur_q);
			lane_in[i] = (cur_q >= region_q[i][ADDR_WIDTH-1:0]) && !lane_d[i][DIFF_W-1]
				&& (lane_d[i] != '0);
		end
	end

	// First matching region wins; an all-zero region ends the search.
	always_comb begin
		hit  = 1'b0;
		stop = 1'b0;
		hidx = '0;
		dsel = '0;
		esel = '0;
		for (int i = 0; i < NUM_SEARCHED; i++) begin
			if (!stop) begin
				if (term_q[i]) begin
					stop = 1'b1;
				end else if (lane_in[i]) begin
					hit  = 1'b1;
					stop = 1'b1;
					hidx = SLOT_W'(i);
					dsel = lane_d[i][END_W-1:0];
					esel = end_q[i][ADDR_WIDTH-1:0];
				end
			end
		end
	end

	// Segment size: the rest of the access or up to the region end, whichever is shorter.
	assign diff     = DIFF_W'(rem_q) - DIFF_W'(dsel);
	assign fits_all = diff[DIFF_W-1] || (diff == '0);
	assign enabled  = hit ? handler_q[{hidx, dir_q}] : default_q[dir_q];

	// Result of this decode cycle.
	always_comb begin
		res_idx    = hit ? IDX_W'(hidx) : DEFAULT_IDX;
		res_len    = rem_q;
		res_status = ST_SERVED;
		res_last   = 1'b1;
		if (empty_q) begin
			res_idx    = '0;
			res_len    = '0;
			res_status = ST_EMPTY;
		end else if (!enabled) begin
			res_len    = '0;
			res_status = ST_ABSENT;
		end else if (hit && !fits_all) begin
			res_len  = dsel[FIELD_W-1:0];
			res_last = 1'b0;
		end
	end

	assign sts.last = res_last;

	// Access state and output register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q   <= in_start_address[ADDR_WIDTH-1:0];
			rem_q   <= clip_count;
			dir_q   <= in_action;
			empty_q <= (in_byte_count == '0);
		end else if (cmd.emit && !res_last) begin
			cur_q <= esel;
			rem_q <= diff[FIELD_W-1:0];
		end
		if (cmd.emit) begin
			idx_q    <= res_idx;
			addr_q   <= FIELD_W'(cur_q);
			len_q    <= res_len;
			status_q <= res_status;
			last_q   <= res_last;
		end
	end

	assign out_region_index    = idx_q;
	assign out_segment_address = addr_q;
	assign out_segment_length  = len_q;
	assign out_status          = status_q;
	assign out_last            = last_q;

`ifndef SYNTH
	// A segment that is not the last moves the address strictly forward.
	a_addr_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !res_last) |=> (cur_q > $past(cur_q)))
		else $error("address did not advance after a partial segment");

	// Only a served, non-empty piece can leave bytes for another segment.
	a_partial_served: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !res_last) |-> (res_status == ST_SERVED && res_len != '0 && hit))
		else $error("partial segment is not a served region hit");
`endif

endmodule

/* design/arsd_ctrl.sv */
// Controller of the region decoder: accepts an access, then steps one segment per decode cycle into
// the output register while that register has room. Depends on arsd_pkg.
module arsd_ctrl
	import arsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic {
		S_IDLE,
		S_DECODE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   room;

	// The output register can take a segment when empty or being drained.
	assign room     = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = in_valid && in_ready;
	assign cmd.emit = (state_q == S_DECODE) && room;
	assign out_valid = out_valid_q;

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (cmd.emit && sts.last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// A new segment never overwrites one that is still waiting.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("segment emitted over a pending one");

	// The final segment returns the controller to idle with the segment shown.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last) |=> (state_q == S_IDLE && out_valid_q))
		else $error("controller did not finish after the final segment");

	// An accepted access is always decoded next.
	a_load_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DECODE))
		else $error("accepted access not decoded");
`endif

endmodule
